@@ rtl/glbt_pkg.sv @@
// ----------------------------------------------------------------------------
// glbt_pkg: shared types and constants of the gas level baseline tracker
// Register indexes, fixed-point constants and the record passed from the
// window stage to the scaling pipeline.
// ----------------------------------------------------------------------------
package glbt_pkg;

  localparam int SAMPLE_W = 32;
  localparam int PROD_W   = 64;
  localparam int MAG_W    = 48;   // rounded magnitude, product >> 16
  localparam int SV_W     = 49;   // signed rounded value
  localparam int SUM_W    = 50;   // signed value plus offset

  localparam logic [SAMPLE_W-1:0] HALF_Q16    = 32'h0000_8000;
  localparam logic [PROD_W-1:0]   ROUND_BIAS  = 64'h0000_0000_0000_8000;
  localparam logic [SAMPLE_W-1:0] GAIN_RESET  = 32'h0001_0000;
  localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 32'h0000_0000;
  localparam logic [SAMPLE_W-1:0] REL_RESET   = 32'h0001_0000;
  localparam logic [SAMPLE_W-1:0] ALARM_RESET = 32'h0001_0000;

  localparam logic signed [SUM_W-1:0] SAT_MAX = 50'sh0_0000_7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] SAT_MIN = -50'sh0_0000_8000_0000;

  // last slot of a group of four samples
  localparam logic [1:0] LAST_POS = 2'd3;

  typedef enum logic [1:0] {
    REG_GAIN_K            = 2'd0,
    REG_OFFSET_B          = 2'd1,
    REG_RELEASE_THRESHOLD = 2'd2,
    REG_ALARM_THRESHOLD   = 2'd3
  } cfg_reg_e;

  // one completed group, ready for scaling
  typedef struct packed {
    logic                half;   // density is the constant one half
    logic [SAMPLE_W-1:0] diff;   // unsigned Q16.16 difference
  } diff_t;

endpackage

@@ rtl/glbt_window.sv @@
// ----------------------------------------------------------------------------
// glbt_window: input register, group window and baseline state
// Collects four samples, runs baseline capture and release, and hands the
// difference of each completed group to the scaling pipeline.
// ----------------------------------------------------------------------------
module glbt_window (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              ratio_sample,
  input  logic [31:0]              release_threshold,
  output logic                     dn_valid,
  input  logic                     dn_free,
  output glbt_pkg::diff_t          dn_data
);
  import glbt_pkg::*;

  logic                s0_valid;
  logic [SAMPLE_W-1:0] sample_q;
  logic                a_valid;
  diff_t               a_data;
  diff_t               a_data_next;

  logic [SAMPLE_W-1:0] window [3];
  logic [1:0]          fill_count;
  logic [SAMPLE_W-1:0] baseline;
  logic                tracking;
  logic                armed;

  logic                a_free;
  logic                s0_free;
  logic                consume;
  logic                last;
  logic                capture;
  logic                track_eff;
  logic [SAMPLE_W-1:0] base_eff;
  logic                above;
  logic [SAMPLE_W-1:0] rise;
  logic                release_hit;
  logic [SAMPLE_W-1:0] abs_diff;

  assign a_free   = !a_valid || dn_free;
  assign s0_free  = !s0_valid || a_free;
  assign in_ready = s0_free;
  assign consume  = s0_valid && a_free;
  assign last     = (fill_count == LAST_POS);

  assign capture   = armed && (window[0] > window[1]) && (window[1] > window[2])
                     && (window[2] > sample_q);
  assign track_eff = tracking || capture;
  assign base_eff  = capture ? sample_q : baseline;
  assign above     = sample_q > base_eff;
  assign rise      = sample_q - base_eff;
  assign release_hit = track_eff && above && (rise > release_threshold);
  assign abs_diff  = (sample_q >= window[2]) ? (sample_q - window[2])
                                             : (window[2] - sample_q);

  always_comb begin
    a_data_next.half = 1'b0;
    a_data_next.diff = abs_diff;
    if (track_eff) begin
      if (above) begin
        a_data_next.half = 1'b1;
        a_data_next.diff = '0;
      end else begin
        a_data_next.diff = base_eff - sample_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid   <= 1'b0;
      a_valid    <= 1'b0;
      fill_count <= '0;
      baseline   <= '0;
      tracking   <= 1'b0;
      armed      <= 1'b1;
      window[0]  <= '0;
      window[1]  <= '0;
      window[2]  <= '0;
    end else begin
      if (s0_free) begin
        s0_valid <= in_valid;
      end
      if (a_free) begin
        a_valid <= consume && last;
      end
      if (consume) begin
        fill_count <= fill_count + 2'd1;
        if (!last) begin
          window[fill_count] <= sample_q;
        end else if (release_hit) begin
          armed    <= 1'b1;
          tracking <= 1'b0;
          baseline <= '0;
        end else if (capture) begin
          armed    <= 1'b0;
          tracking <= 1'b1;
          baseline <= sample_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s0_free) begin
      sample_q <= ratio_sample;
    end
    if (consume && last) begin
      a_data <= a_data_next;
    end
  end

  assign dn_valid = a_valid;
  assign dn_data  = a_data;

endmodule

@@ rtl/glbt_scale.sv @@
// ----------------------------------------------------------------------------
// glbt_scale: gain multiply, rounding, offset and saturation
// Three register stages: product, rounded signed value, result register.
// ----------------------------------------------------------------------------
module glbt_scale (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     up_valid,
  output logic                     up_free,
  input  glbt_pkg::diff_t          up_data,
  input  logic [31:0]              gain_mag,
  input  logic                     gain_neg,
  input  logic [31:0]              offset_b,
  input  logic [31:0]              alarm_threshold,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [31:0]              density,
  output logic                     alarm
);
  import glbt_pkg::*;

  logic                    m_valid;
  logic                    m_half;
  logic [PROD_W-1:0]       m_prod;
  logic                    n_valid;
  logic                    n_half;
  logic signed [SV_W-1:0]  n_val;

  logic                    o_free;
  logic                    n_free;
  logic                    m_free;
  logic [PROD_W-1:0]       rnd_sum;
  logic signed [SV_W-1:0]  mag_s;
  logic signed [SUM_W-1:0] tot;
  logic [SAMPLE_W-1:0]     density_next;
  logic                    alarm_next;

  assign o_free  = !out_valid || out_ready;
  assign n_free  = !n_valid || o_free;
  assign m_free  = !m_valid || n_free;
  assign up_free = m_free;

  // round magnitude to nearest, ties away from zero, then apply the sign
  assign rnd_sum = m_prod + ROUND_BIAS;
  assign mag_s   = $signed({1'b0, rnd_sum[PROD_W-1 -: MAG_W]});

  assign tot = {n_val[SV_W-1], n_val} + {{(SUM_W-SAMPLE_W){offset_b[31]}}, offset_b};

  always_comb begin
    if (n_half) begin
      density_next = HALF_Q16;
    end else if (tot > SAT_MAX) begin
      density_next = SAT_MAX[SAMPLE_W-1:0];
    end else if (tot < SAT_MIN) begin
      density_next = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      density_next = tot[SAMPLE_W-1:0];
    end
    // compare the clamped density so a bottomed-out result still meets
    // the most negative threshold
    alarm_next = $signed(density_next) >= $signed(alarm_threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      n_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_free) begin
        m_valid <= up_valid;
      end
      if (n_free) begin
        n_valid <= m_valid;
      end
      if (o_free) begin
        out_valid <= n_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_free && up_valid) begin
      m_half <= up_data.half;
      m_prod <= PROD_W'(up_data.diff) * PROD_W'(gain_mag);
    end
    if (n_free && m_valid) begin
      n_half <= m_half;
      n_val  <= gain_neg ? -mag_s : mag_s;
    end
    if (o_free && n_valid) begin
      density <= density_next;
      alarm   <= alarm_next;
    end
  end

endmodule

@@ rtl/gas_level_baseline_tracker_top.sv @@
// ----------------------------------------------------------------------------
// gas_level_baseline_tracker_top: gas density from optical power ratios
// Configuration registers, group window with baseline tracking, and the
// scaling pipeline that turns each completed group into one density result.
// ----------------------------------------------------------------------------
// Samples (unsigned Q16.16) arrive on the in_valid/in_ready channel and are
// grouped in fours; only the fourth sample of a group produces a result on
// the out_valid/out_ready channel, the first three produce nothing. One
// sample transfers per clock; a result passes, after the transfer of the
// sample that closes its group, through the input register (loaded at the
// transfer), window stage, multiply, rounding and result register. The
// path stalls only when the result register holds an untaken result and
// every stage behind it is full. Write the configuration registers through
// cfg_write/cfg_index/cfg_data only while the block is idle; a write takes
// effect at once.
// ----------------------------------------------------------------------------
module gas_level_baseline_tracker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] ratio_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] density,
  output logic        alarm
);
  import glbt_pkg::*;

  // gain is kept as sign and magnitude so the multiplier sees an unsigned
  // operand; the most negative gain still fits the 32-bit magnitude
  logic [SAMPLE_W-1:0] gain_mag;
  logic                gain_neg;
  logic [SAMPLE_W-1:0] offset_b;
  logic [SAMPLE_W-1:0] release_threshold;
  logic [SAMPLE_W-1:0] alarm_threshold;

  logic                grp_valid;
  logic                grp_free;
  diff_t               grp_data;

  // register writes: decode the index and capture the data
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_mag          <= GAIN_RESET;
      gain_neg          <= 1'b0;
      offset_b          <= OFFSET_RESET;
      release_threshold <= REL_RESET;
      alarm_threshold   <= ALARM_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_e'(cfg_index))
        REG_GAIN_K: begin
          gain_neg <= cfg_data[31];
          gain_mag <= cfg_data[31] ? (~cfg_data + 32'd1) : cfg_data;
        end
        REG_OFFSET_B:          offset_b          <= cfg_data;
        REG_RELEASE_THRESHOLD: release_threshold <= cfg_data;
        REG_ALARM_THRESHOLD:   alarm_threshold   <= cfg_data;
        default: ;
      endcase
    end
  end

  // group window: capture, track and release the baseline, form the difference
  glbt_window u_window (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .ratio_sample      (ratio_sample),
    .release_threshold (release_threshold),
    .dn_valid          (grp_valid),
    .dn_free           (grp_free),
    .dn_data           (grp_data)
  );

  // scale by gain, round, add offset, saturate and compare against the alarm
  glbt_scale u_scale (
    .clk             (clk),
    .rst             (rst),
    .up_valid        (grp_valid),
    .up_free         (grp_free),
    .up_data         (grp_data),
    .gain_mag        (gain_mag),
    .gain_neg        (gain_neg),
    .offset_b        (offset_b),
    .alarm_threshold (alarm_threshold),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .density         (density),
    .alarm           (alarm)
  );

endmodule

@@ tb/gas_level_baseline_tracker_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_level_baseline_tracker_top_test: self-checking bench for the tracker
// Streams ratio samples in groups of four, predicts density and alarm for
// each completed group, and compares every result in order. Covers baseline
// capture, tracking, the release threshold, rounding and saturation, under
// random stalls on both channels and several register settings.
// ----------------------------------------------------------------------------
module gas_level_baseline_tracker_top_test;
  import glbt_pkg::*;

  typedef struct packed {
    logic [31:0] exp_density;
    logic        exp_alarm;
  } density_result_t;

  // Signals toward the block start at known values; rst is high from time 0.
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_write    = 1'b0;
  logic [1:0]  cfg_index    = REG_GAIN_K;
  logic [31:0] cfg_data     = 32'd0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [31:0] ratio_sample = 32'd0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [31:0] density;
  logic        alarm;

  // When set, neither side idles: the long stretch of back-to-back transfers.
  bit quiet = 1'b0;
  int error_count = 0;
  int samples_sent = 0;

  // Tracker state as the block should hold it, plus its register copies.
  logic [31:0] win_samples [4];
  logic [1:0]  fill_pos;
  logic [31:0] base_level;
  logic        is_tracking;
  logic        is_armed;
  logic [31:0] k_gain, b_offset, rel_thresh, alarm_thresh;

  // Density results still owed by the block, oldest first.
  density_result_t density_due [$];

  gas_level_baseline_tracker_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ratio_sample (ratio_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .density      (density),
    .alarm        (alarm)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("** gas_level_baseline_tracker_top: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Density prediction
  // --------------------------------------------------------------------------
  function automatic void reset_tracker_model();
    foreach (win_samples[i]) win_samples[i] = 32'd0;
    fill_pos     = 2'd0;
    base_level   = 32'd0;
    is_tracking  = 1'b0;
    is_armed     = 1'b1;
    k_gain       = GAIN_RESET;
    b_offset     = OFFSET_RESET;
    rel_thresh   = REL_RESET;
    alarm_thresh = ALARM_RESET;
  endfunction

  // Scale a difference by the gain: round the magnitude half away from zero,
  // restore the sign, add the offset and clamp to signed 32 bits.
  function automatic longint scaled_density(logic [31:0] diff);
    longint      k;
    logic [63:0] mag_k, prod, mag;
    longint      v;
    k     = longint'($signed(k_gain));
    mag_k = (k < 0) ? 64'(-k) : 64'(k);
    prod  = {32'd0, diff} * mag_k;
    mag   = (prod + 64'h8000) >> 16;
    v     = longint'(mag);
    if (k < 0) v = -v;
    v += longint'($signed(b_offset));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  // Advance the tracker by one accepted sample; queue a result on group end.
  function automatic void take_sample(logic [31:0] s);
    logic [1:0]  pos;
    longint      dens;
    logic [31:0] a, b;
    pos = fill_pos;
    win_samples[pos] = s;
    if (pos != LAST_POS) begin
      fill_pos = pos + 2'd1;
      return;
    end
    fill_pos = 2'd0;

    if (is_armed && win_samples[0] > win_samples[1] &&
        win_samples[1] > win_samples[2] && win_samples[2] > win_samples[3]) begin
      base_level  = s;
      is_armed    = 1'b0;
      is_tracking = 1'b1;
    end

    if (is_tracking) begin
      if (base_level >= s) begin
        dens = scaled_density(base_level - s);
      end else begin
        // Above baseline: fixed one half; release uses the pre-release density.
        dens = longint'(HALF_Q16);
        if (s - base_level > rel_thresh) begin
          is_armed    = 1'b1;
          is_tracking = 1'b0;
          base_level  = 32'd0;
        end
      end
    end else begin
      a = win_samples[3];
      b = win_samples[2];
      dens = scaled_density((a >= b) ? a - b : b - a);
    end

    density_due.push_back('{exp_density: dens[31:0],
                            exp_alarm: (dens >= longint'($signed(alarm_thresh)))});
  endfunction

  // --------------------------------------------------------------------------
  // Result checking and receiver stalls
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin : result_check
    density_result_t due;
    if (!rst && out_valid && out_ready) begin
      if (density_due.size() == 0) begin
        report_mismatch("density result with none pending", 32'd0, density);
      end else begin
        due = density_due.pop_front();
        if (density !== due.exp_density)
          report_mismatch("density", due.exp_density, density);
        if (alarm !== due.exp_alarm)
          report_mismatch("alarm", {31'd0, due.exp_alarm}, {31'd0, alarm});
      end
    end
    // Stall the result channel with a chance of about one in five unless quiet.
    out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 20);
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------
  // Offer one sample and hold it until the transfer; valid stays high into the
  // next call unless that call opens a gap.
  task automatic send_sample(input logic [31:0] s);
    if (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 20);
    end
    in_valid     <= 1'b1;
    ratio_sample <= s;
    do @(posedge clk); while (!in_ready);
    take_sample(s);
    samples_sent++;
  endtask

  task automatic send_group(input logic [31:0] w0, w1, w2, w3);
    send_sample(w0);
    send_sample(w1);
    send_sample(w2);
    send_sample(w3);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline settle in
  // case a non-closing sample is still in flight.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (density_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Write one register; the caller lowers cfg_write after the last write.
  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      REG_GAIN_K:            k_gain       = v;
      REG_OFFSET_B:          b_offset     = v;
      REG_RELEASE_THRESHOLD: rel_thresh   = v;
      REG_ALARM_THRESHOLD:   alarm_thresh = v;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [31:0] gain, offs, rel, thr);
    write_reg(REG_GAIN_K, gain);
    write_reg(REG_OFFSET_B, offs);
    write_reg(REG_RELEASE_THRESHOLD, rel);
    write_reg(REG_ALARM_THRESHOLD, thr);
    cfg_write <= 1'b0;
  endtask

  // Signed register values: extremes, unity, zero, small and full random.
  function automatic logic [31:0] pick_signed_word();
    case ($urandom_range(0, 6))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'd0;
      3:       return 32'h0001_0000;
      4:       return $urandom_range(0, 32'h0002_0000);
      5:       return 32'd0 - $urandom_range(0, 32'h0002_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_threshold();
    case ($urandom_range(0, 4))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  // One random group, steered by the tracker state toward capture, tracking
  // below baseline, a rise within or exactly at the threshold, or a release.
  task automatic send_random_group();
    logic [31:0] w0, w1, w2, w3;
    logic [32:0] sum;
    int          r;
    // Occasionally slip a stray sample in to shift group alignment.
    if ($urandom_range(0, 99) < 5) send_sample($urandom);
    while (fill_pos != 2'd0) send_sample($urandom);

    r  = $urandom_range(0, 99);
    w0 = $urandom;
    w1 = $urandom;
    w2 = $urandom;
    w3 = $urandom;
    if (!is_tracking) begin
      if (r < 55) begin
        // Strictly falling group: triggers the baseline capture.
        if (w0 < 32'd3) w0 = 32'd3;
        w1 = $urandom_range(2, w0 - 1);
        w2 = $urandom_range(1, w1 - 1);
        w3 = $urandom_range(0, w2 - 1);
      end
    end else if (r < 35) begin
      w3 = $urandom_range(0, base_level);
    end else if (r < 55) begin
      // Rise within the threshold: one half, tracking holds.
      if (base_level != 32'hFFFF_FFFF) begin
        sum = {1'b0, base_level} + {1'b0, rel_thresh};
        w3 = $urandom_range(base_level + 1,
                            sum[32] ? 32'hFFFF_FFFF : sum[31:0]);
      end
    end else if (r < 65) begin
      // Rise exactly at the threshold: no release.
      sum = {1'b0, base_level} + {1'b0, rel_thresh};
      if (!sum[32]) w3 = sum[31:0];
    end else if (r < 80) begin
      // Rise just past the threshold: release.
      sum = {1'b0, base_level} + {1'b0, rel_thresh} + 33'd1;
      if (!sum[32]) w3 = sum[31:0];
    end
    send_group(w0, w1, w2, w3);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset registers; a non-falling group with full-scale swings saturates high.
  task automatic test_reset_defaults();
    send_group(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
  endtask

  // Capture on a falling group, track below and above baseline, hold at a
  // rise equal to the threshold, release just past it.
  task automatic test_capture_track_release();
    send_group(32'h0005_0000, 32'h0004_0000, 32'h0003_0000, 32'h0002_0000);
    send_group(32'd0, 32'd0, 32'd0, 32'h0001_0000);
    send_group(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE, 32'h0003_0000);
    send_group(32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0003_0001);
  endtask

  // Most negative gain, largest offset, widest release, lowest alarm level.
  task automatic test_saturation_extremes();
    drain_results();
    load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    send_group(32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    drain_results();
  endtask

  // Six phases of random groups, each under its own register setting; the
  // first uses the opposite extremes, the third runs without idling.
  task automatic test_random_phases();
    int start;
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0)
        load_config(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF);
      else
        load_config(pick_signed_word(), pick_signed_word(), pick_threshold(),
                    pick_signed_word());
      quiet = (phase == 2);
      start = samples_sent;
      while (samples_sent - start < 160) send_random_group();
      drain_results();
      quiet = 1'b0;
    end
  endtask

  initial begin
    reset_tracker_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_capture_track_release();
    test_saturation_extremes();
    test_random_phases();
    drain_results();

    if (error_count == 0 && density_due.size() == 0) begin
      $display("** gas_level_baseline_tracker_top: PASSED **");
    end else begin
      $display("** gas_level_baseline_tracker_top: FAILED **");
    end
    $finish;
  end

endmodule
